// File: hw/rtl/dbt_pkg.sv
// ----------------------------------------------------------------------------
// dbt_pkg
// Shared types and constants for the byte tokenizer.
// ----------------------------------------------------------------------------
package dbt_pkg;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_SLASH = 4'd1,
        M_LCOM  = 4'd2,
        M_BCOM  = 4'd3,
        M_BSTAR = 4'd4,
        M_PAIR  = 4'd5,
        M_STR   = 4'd6,
        M_ESC   = 4'd7,
        M_INT   = 4'd8,
        M_IDOT  = 4'd9,
        M_FRAC  = 4'd10,
        M_IDENT = 4'd11
    } mode_t;

    localparam logic [5:0] K_ARROW   = 6'd14;
    localparam logic [5:0] K_MINUS   = 6'd15;
    localparam logic [5:0] K_EQEQ    = 6'd16;
    localparam logic [5:0] K_EQ      = 6'd17;
    localparam logic [5:0] K_NE      = 6'd18;
    localparam logic [5:0] K_BANG    = 6'd19;
    localparam logic [5:0] K_LE      = 6'd20;
    localparam logic [5:0] K_LT      = 6'd21;
    localparam logic [5:0] K_GE      = 6'd22;
    localparam logic [5:0] K_GT      = 6'd23;
    localparam logic [5:0] K_AND     = 6'd24;
    localparam logic [5:0] K_OR      = 6'd25;
    localparam logic [5:0] K_DOT     = 6'd9;
    localparam logic [5:0] K_SLASH   = 6'd26;
    localparam logic [5:0] K_STRING  = 6'd27;
    localparam logic [5:0] K_INT     = 6'd28;
    localparam logic [5:0] K_DEC     = 6'd29;
    localparam logic [5:0] K_IDENT   = 6'd30;
    localparam logic [5:0] K_DUR     = 6'd31;
    localparam logic [5:0] K_UNKNOWN = 6'd32;
    localparam logic [5:0] K_END     = 6'd33;
    localparam logic [5:0] K_NONE    = 6'd63;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_AMP     = 3'd1;
    localparam logic [2:0] E_BAR     = 3'd2;
    localparam logic [2:0] E_BYTE    = 3'd3;
    localparam logic [2:0] E_COMMENT = 3'd4;
    localparam logic [2:0] E_STRING  = 3'd5;

    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_US = 8'h5F;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Which of up to three positions a token takes its start from.
    typedef enum logic [1:0] {
        P_BEGIN = 2'd0,
        P_CUR   = 2'd1,
        P_DOT   = 2'd2
    } pos_sel_t;

    // Which offset a token ends at.
    typedef enum logic [1:0] {
        E_AT_CUR  = 2'd0,
        E_AT_NEXT = 2'd1,
        E_AT_DOT  = 2'd2
    } end_sel_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] kind;
        logic [2:0] err;
        pos_sel_t   pos;
        end_sel_t   fin;
    } tok_t;

    function automatic logic is_dig(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            8'h7B:   return 6'd0;
            8'h7D:   return 6'd1;
            8'h28:   return 6'd2;
            8'h29:   return 6'd3;
            8'h5B:   return 6'd4;
            8'h5D:   return 6'd5;
            8'h2C:   return 6'd6;
            8'h3A:   return 6'd7;
            8'h3B:   return 6'd8;
            8'h2E:   return 6'd9;
            8'h3F:   return 6'd10;
            8'h2B:   return 6'd11;
            8'h2A:   return 6'd12;
            8'h25:   return 6'd13;
            default: return K_NONE;
        endcase
    endfunction

endpackage

// File: hw/rtl/dsl_byte_tokenizer_top.sv
// ----------------------------------------------------------------------------
// dsl_byte_tokenizer_top
// Streaming tokenizer: one source byte per transaction, up to three tokens out.
// ----------------------------------------------------------------------------
// Output: a token appears at the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle when a byte causes at most one token and out_ready
// is high; a byte causing more tokens holds the input while the token queue drains.
// Reset: rst_n clears the mode, the position counters (line and column to 1) and the
// output queue; the end-of-text transaction restores the mode and the counters only.
module dsl_byte_tokenizer_top #(
    parameter int OFFSET_WIDTH = 32,
    parameter int LINE_WIDTH   = 24,
    parameter int COLUMN_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [31:0] start_offset,
    output logic [31:0] token_length,
    output logic [23:0] start_line,
    output logic [15:0] start_column,
    output logic [2:0]  error_code,
    output logic        last_of_run
);

    localparam int OW = OFFSET_WIDTH;
    localparam int LW = LINE_WIDTH;
    localparam int CW = COLUMN_WIDTH;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] off;
        logic [31:0] len;
        logic [23:0] line;
        logic [15:0] col;
        logic [2:0]  err;
        logic        last;
    } res_t;

    dbt_pkg::mode_t mode_reg, mode_next;
    logic [7:0]  pend_reg, pend_next;
    logic [4:0]  df_reg, df_next;
    logic [OW-1:0] boff_reg, coff_reg, doff_reg;
    logic [LW-1:0] bline_reg, cline_reg, dline_reg;
    logic [CW-1:0] bcol_reg, ccol_reg, dcol_reg;
    logic [OW-1:0] noff;
    logic [LW-1:0] nline;
    logic [CW-1:0] ncol;

    logic          begin_load, dot_load;
    dbt_pkg::tok_t tk [3];
    res_t          rs [3];
    logic [2:0]    vmask;

    res_t        q_reg [3];
    logic [1:0]  cnt_reg;
    logic [1:0]  ncount;
    logic        acc, pop;

    dbt_scan u_scan (
        .mode        (mode_reg),
        .pend        (pend_reg),
        .dflags      (df_reg),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .mode_next   (mode_next),
        .pend_next   (pend_next),
        .dflags_next (df_next),
        .begin_load  (begin_load),
        .dot_load    (dot_load),
        .tok0        (tk[0]),
        .tok1        (tk[1]),
        .tok2        (tk[2])
    );

    assign noff  = (&coff_reg) ? coff_reg : coff_reg + 1'b1;
    assign nline = (text_byte == dbt_pkg::CH_LF && !(&cline_reg)) ? cline_reg + 1'b1
                                                                   : cline_reg;
    assign ncol  = (text_byte == dbt_pkg::CH_LF) ? CW'(1)
                 : ((&ccol_reg) ? ccol_reg : ccol_reg + 1'b1);

    always_comb
    begin
        logic [OW-1:0] so;
        logic [OW-1:0] eo;
        logic [LW-1:0] sl;
        logic [CW-1:0] sc;
        for (int i = 0; i < 3; i++)
        begin
            case (tk[i].pos)
                dbt_pkg::P_CUR:
                begin
                    so = coff_reg; sl = cline_reg; sc = ccol_reg;
                end
                dbt_pkg::P_DOT:
                begin
                    so = doff_reg; sl = dline_reg; sc = dcol_reg;
                end
                default:
                begin
                    so = boff_reg; sl = bline_reg; sc = bcol_reg;
                end
            endcase
            case (tk[i].fin)
                dbt_pkg::E_AT_NEXT: eo = noff;
                dbt_pkg::E_AT_DOT:  eo = doff_reg;
                default:            eo = coff_reg;
            endcase
            rs[i].kind = tk[i].kind;
            rs[i].err  = tk[i].err;
            rs[i].off  = 32'(so);
            rs[i].len  = (eo >= so) ? 32'(eo - so) : 32'd0;
            rs[i].line = 24'(sl);
            rs[i].col  = 16'(sc);
            rs[i].last = 1'b0;
            vmask[i]   = tk[i].valid;
        end
        if (vmask[2])
        begin
            rs[2].last = 1'b1;
        end
        else if (vmask[1])
        begin
            rs[1].last = 1'b1;
        end
        else
        begin
            rs[0].last = 1'b1;
        end
    end

    // Tokens are always packed from slot 0, so the count is the number of valid slots.
    assign ncount = vmask[2] ? 2'd3 : (vmask[1] ? 2'd2 : (vmask[0] ? 2'd1 : 2'd0));
    assign pop      = out_valid && out_ready;
    assign in_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign acc      = in_valid && in_ready;

    assign out_valid    = cnt_reg != 2'd0;
    assign token_kind   = q_reg[0].kind;
    assign start_offset = q_reg[0].off;
    assign token_length = q_reg[0].len;
    assign start_line   = q_reg[0].line;
    assign start_column = q_reg[0].col;
    assign error_code   = q_reg[0].err;
    assign last_of_run  = q_reg[0].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (acc)
        begin
            cnt_reg <= ncount;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[0] <= rs[0];
            q_reg[1] <= rs[1];
            q_reg[2] <= rs[2];
        end
        else if (pop)
        begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= dbt_pkg::M_IDLE;
            pend_reg  <= '0;
            df_reg    <= '0;
            boff_reg  <= '0;
            bline_reg <= LW'(1);
            bcol_reg  <= CW'(1);
            coff_reg  <= '0;
            cline_reg <= LW'(1);
            ccol_reg  <= CW'(1);
            doff_reg  <= '0;
            dline_reg <= LW'(1);
            dcol_reg  <= CW'(1);
        end
        else if (acc)
        begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            df_reg   <= df_next;
            if (end_of_text)
            begin
                boff_reg  <= '0;
                bline_reg <= LW'(1);
                bcol_reg  <= CW'(1);
                coff_reg  <= '0;
                cline_reg <= LW'(1);
                ccol_reg  <= CW'(1);
                doff_reg  <= '0;
                dline_reg <= LW'(1);
                dcol_reg  <= CW'(1);
            end
            else
            begin
                coff_reg  <= noff;
                cline_reg <= nline;
                ccol_reg  <= ncol;
                if (begin_load)
                begin
                    boff_reg  <= coff_reg;
                    bline_reg <= cline_reg;
                    bcol_reg  <= ccol_reg;
                end
                if (dot_load)
                begin
                    doff_reg  <= coff_reg;
                    dline_reg <= cline_reg;
                    dcol_reg  <= ccol_reg;
                end
            end
        end
    end

endmodule

// File: hw/rtl/dbt_scan.sv
// ----------------------------------------------------------------------------
// dbt_scan
// Mode transition logic: decides the next mode and up to three tokens.
// ----------------------------------------------------------------------------
module dbt_scan (
    input  dbt_pkg::mode_t     mode,
    input  logic [7:0]         pend,
    input  logic [4:0]         dflags,
    input  logic [7:0]         text_byte,
    input  logic               end_of_text,
    output dbt_pkg::mode_t     mode_next,
    output logic [7:0]         pend_next,
    output logic [4:0]         dflags_next,
    output logic               begin_load,
    output logic               dot_load,
    output dbt_pkg::tok_t      tok0,
    output dbt_pkg::tok_t      tok1,
    output dbt_pkg::tok_t      tok2
);

    logic [7:0]    b;
    logic          ws;
    logic          do_start;
    logic [5:0]    sk;
    logic [4:0]    idf;
    logic          need_ok;
    dbt_pkg::tok_t pre0;
    dbt_pkg::tok_t pre1;
    dbt_pkg::tok_t st;
    dbt_pkg::tok_t pairf;
    dbt_pkg::tok_t end_tok;
    dbt_pkg::mode_t st_mode;
    logic [7:0]    st_pend;
    logic [4:0]    st_df;

    assign b = text_byte;
    assign ws = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
    assign sk = dbt_pkg::single_kind(b);
    assign need_ok = dflags[0] && dflags[4] && dflags[1] && dflags[2];

    function automatic dbt_pkg::tok_t mk(input logic [5:0] k, input logic [2:0] e,
                                         input dbt_pkg::pos_sel_t p,
                                         input dbt_pkg::end_sel_t f);
        dbt_pkg::tok_t t;
        t.valid = 1'b1;
        t.kind  = k;
        t.err   = e;
        t.pos   = p;
        t.fin   = f;
        return t;
    endfunction

    always_comb
    begin
        pairf = mk(dbt_pkg::K_UNKNOWN, dbt_pkg::E_BAR, dbt_pkg::P_BEGIN, dbt_pkg::E_AT_CUR);
        case (pend)
            8'h2D: pairf.kind = dbt_pkg::K_MINUS;
            8'h3D: pairf.kind = dbt_pkg::K_EQ;
            8'h21: pairf.kind = dbt_pkg::K_BANG;
            8'h3C: pairf.kind = dbt_pkg::K_LT;
            8'h3E: pairf.kind = dbt_pkg::K_GT;
            8'h26: pairf.err  = dbt_pkg::E_AMP;
            default: pairf.err = dbt_pkg::E_BAR;
        endcase
        if (pairf.kind != dbt_pkg::K_UNKNOWN)
        begin
            pairf.err = dbt_pkg::E_NONE;
        end
    end

    // Behaviour of a byte scanned from the idle mode; its start is the current position.
    always_comb
    begin
        st      = '0;
        st_mode = dbt_pkg::M_IDLE;
        st_pend = pend;
        st_df   = dflags;
        if (ws)
        begin
            st_mode = dbt_pkg::M_IDLE;
        end
        else if (sk != dbt_pkg::K_NONE)
        begin
            st = mk(sk, dbt_pkg::E_NONE, dbt_pkg::P_CUR, dbt_pkg::E_AT_NEXT);
        end
        else if (b == 8'h2F)
        begin
            st_mode = dbt_pkg::M_SLASH;
        end
        else if (b == 8'h2D || b == 8'h3D || b == 8'h21 || b == 8'h3C || b == 8'h3E
                 || b == 8'h26 || b == 8'h7C)
        begin
            st_mode = dbt_pkg::M_PAIR;
            st_pend = b;
        end
        else if (b == 8'h22)
        begin
            st_mode = dbt_pkg::M_STR;
        end
        else if (dbt_pkg::is_dig(b))
        begin
            st_mode = dbt_pkg::M_INT;
        end
        else if (dbt_pkg::is_alpha(b))
        begin
            st_mode = dbt_pkg::M_IDENT;
            st_df   = (b == dbt_pkg::CH_P) ? 5'b10001 : 5'b00000;
        end
        else
        begin
            st = mk(dbt_pkg::K_UNKNOWN, dbt_pkg::E_BYTE, dbt_pkg::P_CUR, dbt_pkg::E_AT_NEXT);
        end
    end

    always_comb
    begin
        idf = dflags;
        if (dflags[0])
        begin
            if (dbt_pkg::is_dig(b))
            begin
                idf[1] = 1'b1;
            end
            else if (b == dbt_pkg::CH_T)
            begin
                if (dflags[3])
                begin
                    idf[0] = 1'b0;
                end
                else
                begin
                    idf[3] = 1'b1;
                end
            end
            else if (b == 8'h44 || b == 8'h48 || b == 8'h4D || b == 8'h53)
            begin
                idf[2] = 1'b1;
            end
            else
            begin
                idf[0] = 1'b0;
            end
        end
    end

    always_comb
    begin
        mode_next   = mode;
        pend_next   = pend;
        dflags_next = dflags;
        begin_load  = 1'b0;
        dot_load    = 1'b0;
        pre0        = '0;
        pre1        = '0;
        end_tok     = '0;
        do_start    = 1'b0;
        tok0        = '0;
        tok1        = '0;
        tok2        = '0;
        if (end_of_text)
        begin
            mode_next   = dbt_pkg::M_IDLE;
            pend_next   = '0;
            dflags_next = '0;
            end_tok = mk(dbt_pkg::K_END, dbt_pkg::E_NONE, dbt_pkg::P_CUR, dbt_pkg::E_AT_CUR);
            unique case (mode)
                dbt_pkg::M_SLASH: pre0 = mk(dbt_pkg::K_SLASH, dbt_pkg::E_NONE,
                                             dbt_pkg::P_BEGIN, dbt_pkg::E_AT_CUR);
                dbt_pkg::M_BCOM, dbt_pkg::M_BSTAR: end_tok.err = dbt_pkg::E_COMMENT;
                dbt_pkg::M_PAIR:  pre0 = pairf;
                dbt_pkg::M_STR, dbt_pkg::M_ESC: pre0 = mk(dbt_pkg::K_STRING, dbt_pkg::E_STRING,
                                             dbt_pkg::P_BEGIN, dbt_pkg::E_AT_CUR);
                dbt_pkg::M_INT:   pre0 = mk(dbt_pkg::K_INT, dbt_pkg::E_NONE,
                                             dbt_pkg::P_BEGIN, dbt_pkg::E_AT_CUR);
                dbt_pkg::M_IDOT:
                begin
                    pre0 = mk(dbt_pkg::K_INT, dbt_pkg::E_NONE, dbt_pkg::P_BEGIN,
                              dbt_pkg::E_AT_DOT);
                    pre1 = mk(dbt_pkg::K_DOT, dbt_pkg::E_NONE, dbt_pkg::P_DOT,
                              dbt_pkg::E_AT_CUR);
                end
                dbt_pkg::M_FRAC:  pre0 = mk(dbt_pkg::K_DEC, dbt_pkg::E_NONE,
                                             dbt_pkg::P_BEGIN, dbt_pkg::E_AT_CUR);
                dbt_pkg::M_IDENT: pre0 = mk(need_ok ? dbt_pkg::K_DUR : dbt_pkg::K_IDENT,
                                             dbt_pkg::E_NONE, dbt_pkg::P_BEGIN,
                                             dbt_pkg::E_AT_CUR);
                default: ;
            endcase
            tok0 = pre0;
            tok1 = pre1;
            if (pre1.valid)
            begin
                tok2 = end_tok;
            end
            else if (pre0.valid)
            begin
                tok1 = end_tok;
            end
            else
            begin
                tok0 = end_tok;
            end
        end
        else
        begin
            unique case (mode)
                dbt_pkg::M_SLASH:
                begin
                    if (b == 8'h2F)
                    begin
                        mode_next = dbt_pkg::M_LCOM;
                    end
                    else if (b == 8'h2A)
                    begin
                        mode_next = dbt_pkg::M_BCOM;
                    end
                    else
                    begin
                        pre0 = mk(dbt_pkg::K_SLASH, dbt_pkg::E_NONE, dbt_pkg::P_BEGIN,
                                  dbt_pkg::E_AT_CUR);
                        do_start = 1'b1;
                    end
                end
                dbt_pkg::M_LCOM:
                begin
                    if (b == dbt_pkg::CH_LF)
                    begin
                        mode_next = dbt_pkg::M_IDLE;
                    end
                end
                dbt_pkg::M_BCOM:
                begin
                    if (b == 8'h2A)
                    begin
                        mode_next = dbt_pkg::M_BSTAR;
                    end
                end
                dbt_pkg::M_BSTAR:
                begin
                    if (b == 8'h2F)
                    begin
                        mode_next = dbt_pkg::M_IDLE;
                    end
                    else if (b != 8'h2A)
                    begin
                        mode_next = dbt_pkg::M_BCOM;
                    end
                end
                dbt_pkg::M_PAIR:
                begin
                    if (pend == 8'h2D && dbt_pkg::is_dig(b))
                    begin
                        mode_next = dbt_pkg::M_INT;
                    end
                    else if (pend == 8'h2D && b == 8'h3E)
                    begin
                        mode_next = dbt_pkg::M_IDLE;
                        pre0 = mk(dbt_pkg::K_ARROW, dbt_pkg::E_NONE, dbt_pkg::P_BEGIN,
                                  dbt_pkg::E_AT_NEXT);
                    end
                    else if (b == 8'h3D && (pend == 8'h3D || pend == 8'h21 || pend == 8'h3C
                             || pend == 8'h3E))
                    begin
                        mode_next = dbt_pkg::M_IDLE;
                        pre0 = mk(dbt_pkg::K_EQEQ, dbt_pkg::E_NONE, dbt_pkg::P_BEGIN,
                                  dbt_pkg::E_AT_NEXT);
                        case (pend)
                            8'h21:   pre0.kind = dbt_pkg::K_NE;
                            8'h3C:   pre0.kind = dbt_pkg::K_LE;
                            8'h3E:   pre0.kind = dbt_pkg::K_GE;
                            default: pre0.kind = dbt_pkg::K_EQEQ;
                        endcase
                    end
                    else if (pend == 8'h26 && b == 8'h26)
                    begin
                        mode_next = dbt_pkg::M_IDLE;
                        pre0 = mk(dbt_pkg::K_AND, dbt_pkg::E_NONE, dbt_pkg::P_BEGIN,
                                  dbt_pkg::E_AT_NEXT);
                    end
                    else if (pend == 8'h7C && b == 8'h7C)
                    begin
                        mode_next = dbt_pkg::M_IDLE;
                        pre0 = mk(dbt_pkg::K_OR, dbt_pkg::E_NONE, dbt_pkg::P_BEGIN,
                                  dbt_pkg::E_AT_NEXT);
                    end
                    else
                    begin
                        pre0 = pairf;
                        do_start = 1'b1;
                    end
                end
                dbt_pkg::M_STR:
                begin
                    if (b == 8'h5C)
                    begin
                        mode_next = dbt_pkg::M_ESC;
                    end
                    else if (b == 8'h22)
                    begin
                        mode_next = dbt_pkg::M_IDLE;
                        pre0 = mk(dbt_pkg::K_STRING, dbt_pkg::E_NONE, dbt_pkg::P_BEGIN,
                                  dbt_pkg::E_AT_NEXT);
                    end
                end
                dbt_pkg::M_ESC:
                begin
                    mode_next = dbt_pkg::M_STR;
                end
                dbt_pkg::M_INT:
                begin
                    if (b == 8'h2E)
                    begin
                        mode_next = dbt_pkg::M_IDOT;
                        dot_load  = 1'b1;
                    end
                    else if (!dbt_pkg::is_dig(b))
                    begin
                        pre0 = mk(dbt_pkg::K_INT, dbt_pkg::E_NONE, dbt_pkg::P_BEGIN,
                                  dbt_pkg::E_AT_CUR);
                        do_start = 1'b1;
                    end
                end
                dbt_pkg::M_IDOT:
                begin
                    if (dbt_pkg::is_dig(b))
                    begin
                        mode_next = dbt_pkg::M_FRAC;
                    end
                    else
                    begin
                        pre0 = mk(dbt_pkg::K_INT, dbt_pkg::E_NONE, dbt_pkg::P_BEGIN,
                                  dbt_pkg::E_AT_DOT);
                        pre1 = mk(dbt_pkg::K_DOT, dbt_pkg::E_NONE, dbt_pkg::P_DOT,
                                  dbt_pkg::E_AT_CUR);
                        do_start = 1'b1;
                    end
                end
                dbt_pkg::M_FRAC:
                begin
                    if (!dbt_pkg::is_dig(b))
                    begin
                        pre0 = mk(dbt_pkg::K_DEC, dbt_pkg::E_NONE, dbt_pkg::P_BEGIN,
                                  dbt_pkg::E_AT_CUR);
                        do_start = 1'b1;
                    end
                end
                dbt_pkg::M_IDENT:
                begin
                    if (dbt_pkg::is_alpha(b) || dbt_pkg::is_dig(b) || b == dbt_pkg::CH_US)
                    begin
                        dflags_next = idf;
                    end
                    else
                    begin
                        pre0 = mk(need_ok ? dbt_pkg::K_DUR : dbt_pkg::K_IDENT,
                                  dbt_pkg::E_NONE, dbt_pkg::P_BEGIN, dbt_pkg::E_AT_CUR);
                        do_start = 1'b1;
                    end
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase
            tok0 = pre0;
            tok1 = pre1;
            if (do_start)
            begin
                begin_load  = 1'b1;
                mode_next   = st_mode;
                pend_next   = st_pend;
                dflags_next = st_df;
                if (pre1.valid)
                begin
                    tok2 = st;
                end
                else if (pre0.valid)
                begin
                    tok1 = st;
                end
                else
                begin
                    tok0 = st;
                end
            end
        end
    end

endmodule

// File: hw/rtl/dbt_checker.sv
// ----------------------------------------------------------------------------
// dbt_checker
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module dbt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       end_of_text,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] token_kind,
    input logic [2:0] error_code
);

    // An end-of-text transaction must make out_valid high in the next cycle.
    a_end_gives_token: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_text |=> out_valid)
        else $error("end of text produced no token");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= 6'd33)
        else $error("token kind out of range");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> error_code <= 3'd5)
        else $error("error code out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind))
        else $error("output transaction changed while stalled");

endmodule

bind dsl_byte_tokenizer_top dbt_checker u_dbt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .token_kind  (token_kind),
    .error_code  (error_code)
);
